// File: hdl/pbsq_pkg.sv
// pbsq_pkg: shared types, codes and constants of the pointer button scroll qualifier
// no dependencies; imported by the top level

package pbsq_pkg;

  // q12 full scale
  localparam logic [12:0] Q12_ONE = 13'd4096;

  // register reset values
  localparam logic [12:0] TRIG_THR_RST    = 13'd2253;
  localparam logic [12:0] SCROLL_THR_RST  = 13'd2458;
  localparam logic [15:0] REP_DELAY_RST   = 16'd350;
  localparam logic [15:0] REP_IVL_RST     = 16'd100;
  localparam logic [15:0] BACK_SETTLE_RST = 16'd100;
  localparam logic [2:0]  MAX_REP_RST     = 3'd4;

  // depth of the event queue on the result side
  localparam int EV_SLOTS = 4;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_TRIG_THR    = 3'd0,
    CFG_SCROLL_THR  = 3'd1,
    CFG_REP_DELAY   = 3'd2,
    CFG_REP_IVL     = 3'd3,
    CFG_BACK_SETTLE = 3'd4,
    CFG_MAX_REP     = 3'd5
  } cfg_idx_t;

  // event kinds
  typedef enum logic [2:0] {
    EV_MOVE   = 3'd0,
    EV_DOWN   = 3'd1,
    EV_UP     = 3'd2,
    EV_BACK   = 3'd3,
    EV_SCROLL = 3'd4,
    EV_REJECT = 3'd5
  } ev_kind_t;

  // scroll direction codes
  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_POS  = 2'd1,
    DIR_NEG  = 2'd2
  } dir_t;

  // one controller sample
  typedef struct packed {
    logic               menu_on;
    logic [12:0]        trigger_level;
    logic signed [13:0] stick_y;
    logic               back_pressed;
    logic               has_position;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [31:0]        time_ms;
  } sample_t;

  // one result event
  typedef struct packed {
    ev_kind_t           kind;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [3:0]  steps;
    logic               last;
  } ev_t;

  // build an event, last flag filled in later
  function automatic ev_t mk_ev(ev_kind_t kind, logic signed [15:0] x,
                                logic signed [15:0] y, logic signed [3:0] steps);
    ev_t e;
    e.kind  = kind;
    e.x     = x;
    e.y     = y;
    e.steps = steps;
    e.last  = 1'b0;
    return e;
  endfunction

  // 32-bit add saturating at all ones
  function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

// File: hdl/pbsq_in_if.sv
// pbsq_in_if: sample channel, valid/ready with the sample fields
// no dependencies

interface pbsq_in_if;
  logic               valid;
  logic               ready;
  logic               menu_on;
  logic [12:0]        trigger_level;
  logic signed [13:0] stick_y;
  logic               back_pressed;
  logic               has_position;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic [31:0]        time_ms;

  modport source (
    output valid, menu_on, trigger_level, stick_y, back_pressed,
           has_position, pos_x, pos_y, time_ms,
    input  ready
  );

  modport sink (
    input  valid, menu_on, trigger_level, stick_y, back_pressed,
           has_position, pos_x, pos_y, time_ms,
    output ready
  );
endinterface

// File: hdl/pbsq_out_if.sv
// pbsq_out_if: event channel, valid/ready with the event fields
// no dependencies

interface pbsq_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         event_kind;
  logic signed [15:0] event_x;
  logic signed [15:0] event_y;
  logic signed [3:0]  scroll_steps;
  logic               last_event;

  modport source (
    output valid, event_kind, event_x, event_y, scroll_steps, last_event,
    input  ready
  );

  modport sink (
    input  valid, event_kind, event_x, event_y, scroll_steps, last_event,
    output ready
  );
endinterface

// File: hdl/pointer_button_scroll_qualifier_top.sv
// pointer_button_scroll_qualifier_top: turns controller samples into pointer events
// depends on pbsq_pkg, pbsq_in_if and pbsq_out_if
//
//   channel   dir  handshake      word
//   in_word   in   valid/ready    one controller sample
//   out_word  out  valid/ready    one pointer event, last_event on the final one
//   cfg_*     in   cfg_we         register write, index 0..5, 16-bit data
//
// a sample is qualified from the input register when the queue can take it
// and its 0 to 4 events load a four-slot queue that drains one word a cycle
// while out_word.ready is high; the queue drain sets the sample rate
// the next sample is taken while the last event of the previous one is shown
// synchronous active-low reset clears the queue, the state and the registers
// to their defaults; a stalled output holds the queue and backs up the input

module pointer_button_scroll_qualifier_top
  import pbsq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  pbsq_in_if.sink     in_word,
  pbsq_out_if.source  out_word,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  // configuration registers
  logic [12:0] trig_thr_r;
  logic [12:0] scroll_thr_r;
  logic [15:0] rep_delay_r;
  logic [15:0] rep_ivl_r;
  logic [15:0] back_settle_r;
  logic [2:0]  max_rep_r;

  // input register
  logic    in_valid_r;
  sample_t in_r;

  // qualifier state
  logic        was_active_r,   was_active_nxt;
  logic        trig_held_r,    trig_held_nxt;
  logic        back_held_r,    back_held_nxt;
  logic        back_armed_r,   back_armed_nxt;
  logic        rel_pending_r,  rel_pending_nxt;
  logic [31:0] rel_start_r,    rel_start_nxt;
  dir_t        scroll_dir_r,   scroll_dir_nxt;
  logic [31:0] next_rep_r,     next_rep_nxt;
  logic [31:0] prev_time_r,    prev_time_nxt;

  // event queue
  ev_t        slot_r [EV_SLOTS];
  logic [2:0] cnt_r;

  // handshake
  logic fire;
  logic pop;

  // qualifier datapath
  logic               reject;
  logic               tdown;
  dir_t               dir;
  logic signed [14:0] stick15;
  logic signed [14:0] sthr15;
  logic [15:0]        iv;
  logic [2:0]         cap;
  logic [18:0]        mult [8];
  logic [31:0]        nra;
  logic [31:0]        lag_ms;
  logic [2:0]         reps_raw;
  logic [2:0]         reps;
  logic signed [3:0]  step_val;
  logic [32:0]        settle_end;
  ev_t                ev_new [EV_SLOTS];
  logic [2:0]         n_new;

  // handshake and queue control
  assign pop          = (cnt_r != 3'd0) && out_word.ready;
  assign fire         = in_valid_r && ((cnt_r == 3'd0) || ((cnt_r == 3'd1) && out_word.ready));
  assign in_word.ready = !in_valid_r || fire;

  // output from the queue head
  assign out_word.valid        = (cnt_r != 3'd0);
  assign out_word.event_kind   = slot_r[0].kind;
  assign out_word.event_x      = slot_r[0].x;
  assign out_word.event_y      = slot_r[0].y;
  assign out_word.scroll_steps = slot_r[0].steps;
  assign out_word.last_event   = slot_r[0].last;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_thr_r    <= TRIG_THR_RST;
      scroll_thr_r  <= SCROLL_THR_RST;
      rep_delay_r   <= REP_DELAY_RST;
      rep_ivl_r     <= REP_IVL_RST;
      back_settle_r <= BACK_SETTLE_RST;
      max_rep_r     <= MAX_REP_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TRIG_THR:    trig_thr_r    <= cfg_wdata[12:0];
        CFG_SCROLL_THR:  scroll_thr_r  <= cfg_wdata[12:0];
        CFG_REP_DELAY:   rep_delay_r   <= cfg_wdata;
        CFG_REP_IVL:     rep_ivl_r     <= cfg_wdata;
        CFG_BACK_SETTLE: back_settle_r <= cfg_wdata;
        CFG_MAX_REP:     max_rep_r     <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_word.ready) begin
      in_valid_r <= in_word.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_word.ready && in_word.valid) begin
      in_r.menu_on       <= in_word.menu_on;
      in_r.trigger_level <= in_word.trigger_level;
      in_r.stick_y       <= in_word.stick_y;
      in_r.back_pressed  <= in_word.back_pressed;
      in_r.has_position  <= in_word.has_position;
      in_r.pos_x         <= in_word.pos_x;
      in_r.pos_y         <= in_word.pos_y;
      in_r.time_ms       <= in_word.time_ms;
    end
  end

  // range check, trigger and stick thresholds
  always_comb begin
    stick15 = {in_r.stick_y[13], in_r.stick_y};
    sthr15  = $signed({2'b00, scroll_thr_r});
    reject  = (in_r.trigger_level > Q12_ONE) || (stick15 > 15'sd4096) ||
              (stick15 < -15'sd4096);
    tdown   = (in_r.trigger_level >= trig_thr_r);
    priority if (stick15 >= sthr15) dir = DIR_POS;
    else if (stick15 <= -sthr15)    dir = DIR_NEG;
    else                            dir = DIR_NONE;
  end

  // autorepeat: interval multiples and step count by comparison
  always_comb begin
    logic [2:0] ge_cnt;
    iv  = (rep_ivl_r == 16'd0) ? 16'd1 : rep_ivl_r;
    cap = (max_rep_r == 3'd0) ? 3'd1 : max_rep_r;
    mult[0] = 19'd0;
    mult[1] = {3'b000, iv};
    mult[2] = {2'b00, iv, 1'b0};
    mult[3] = mult[2] + mult[1];
    mult[4] = {1'b0, iv, 2'b00};
    mult[5] = mult[4] + mult[1];
    mult[6] = mult[4] + mult[2];
    mult[7] = mult[6] + mult[1];
    // repeat time restarts when time runs backwards
    if (in_r.time_ms < prev_time_r) begin
      nra = (dir == DIR_NONE) ? 32'd0 : sat_add(in_r.time_ms, {16'd0, rep_delay_r});
    end else begin
      nra = next_rep_r;
    end
    lag_ms = in_r.time_ms - nra;
    ge_cnt = 3'd0;
    for (int k = 1; k < 7; k++) begin
      if (lag_ms >= {13'd0, mult[k]}) ge_cnt = ge_cnt + 3'd1;
    end
    reps_raw = ge_cnt + 3'd1;
    reps     = (reps_raw > cap) ? cap : reps_raw;
    step_val = (dir == DIR_NEG) ? -$signed({1'b0, reps}) : $signed({1'b0, reps});
  end

  // event list and next state for the sample in the input register
  always_comb begin
    was_active_nxt  = was_active_r;
    trig_held_nxt   = trig_held_r;
    back_held_nxt   = back_held_r;
    back_armed_nxt  = back_armed_r;
    rel_pending_nxt = rel_pending_r;
    rel_start_nxt   = rel_start_r;
    scroll_dir_nxt  = scroll_dir_r;
    next_rep_nxt    = next_rep_r;
    prev_time_nxt   = prev_time_r;
    settle_end      = 33'd0;
    n_new           = 3'd0;
    for (int i = 0; i < EV_SLOTS; i++) ev_new[i] = mk_ev(EV_MOVE, 16'sd0, 16'sd0, 4'sd0);

    if (reject) begin
      ev_new[0] = mk_ev(EV_REJECT, 16'sd0, 16'sd0, 4'sd0);
      n_new     = 3'd1;
    end else if (!in_r.menu_on) begin
      // menu left: release a held button, clear everything
      if (was_active_r && trig_held_r) begin
        ev_new[0] = mk_ev(EV_UP, 16'sd0, 16'sd0, 4'sd0);
        n_new     = 3'd1;
      end
      was_active_nxt  = 1'b0;
      trig_held_nxt   = 1'b0;
      back_held_nxt   = 1'b0;
      back_armed_nxt  = 1'b0;
      rel_pending_nxt = 1'b0;
      rel_start_nxt   = 32'd0;
      scroll_dir_nxt  = DIR_NONE;
      next_rep_nxt    = 32'd0;
      prev_time_nxt   = in_r.time_ms;
    end else if (!was_active_r) begin
      // menu entered: take the current levels without events for them
      was_active_nxt  = 1'b1;
      trig_held_nxt   = tdown;
      back_held_nxt   = in_r.back_pressed;
      back_armed_nxt  = 1'b0;
      rel_pending_nxt = !in_r.back_pressed;
      rel_start_nxt   = in_r.back_pressed ? 32'd0 : in_r.time_ms;
      scroll_dir_nxt  = dir;
      next_rep_nxt    = (dir == DIR_NONE) ? 32'd0 :
                        sat_add(in_r.time_ms, {16'd0, rep_delay_r});
      prev_time_nxt   = in_r.time_ms;
      if (in_r.has_position) begin
        ev_new[0] = mk_ev(EV_MOVE, in_r.pos_x, in_r.pos_y, 4'sd0);
        n_new     = 3'd1;
      end
    end else begin
      // pointer move
      if (in_r.has_position) begin
        ev_new[n_new[1:0]] = mk_ev(EV_MOVE, in_r.pos_x, in_r.pos_y, 4'sd0);
        n_new              = n_new + 3'd1;
      end
      // trigger edge
      if (tdown != trig_held_r) begin
        if (tdown && in_r.has_position) begin
          ev_new[n_new[1:0]] = mk_ev(EV_DOWN, in_r.pos_x, in_r.pos_y, 4'sd0);
          n_new              = n_new + 3'd1;
        end else if (!tdown) begin
          ev_new[n_new[1:0]] = mk_ev(EV_UP, 16'sd0, 16'sd0, 4'sd0);
          n_new              = n_new + 3'd1;
        end
        trig_held_nxt = tdown && in_r.has_position;
      end
      // back button settle and press
      if (!back_armed_r) begin
        if (in_r.back_pressed) begin
          rel_pending_nxt = 1'b0;
          rel_start_nxt   = 32'd0;
        end else begin
          if (!rel_pending_r) begin
            rel_pending_nxt = 1'b1;
            rel_start_nxt   = in_r.time_ms;
          end
          settle_end = {1'b0, rel_start_nxt} + {17'd0, back_settle_r};
          if ({1'b0, in_r.time_ms} >= settle_end) back_armed_nxt = 1'b1;
        end
      end else if (in_r.back_pressed && !back_held_r) begin
        ev_new[n_new[1:0]] = mk_ev(EV_BACK, 16'sd0, 16'sd0, 4'sd0);
        n_new              = n_new + 3'd1;
      end
      back_held_nxt = in_r.back_pressed;
      // scroll start and autorepeat
      next_rep_nxt = nra;
      if (dir != scroll_dir_r) begin
        if (dir != DIR_NONE) begin
          ev_new[n_new[1:0]] = mk_ev(EV_SCROLL, 16'sd0, 16'sd0,
                                     (dir == DIR_POS) ? 4'sd1 : -4'sd1);
          n_new              = n_new + 3'd1;
          next_rep_nxt       = sat_add(in_r.time_ms, {16'd0, rep_delay_r});
        end else begin
          next_rep_nxt = 32'd0;
        end
      end else if ((dir != DIR_NONE) && (in_r.time_ms >= nra)) begin
        ev_new[n_new[1:0]] = mk_ev(EV_SCROLL, 16'sd0, 16'sd0, step_val);
        n_new              = n_new + 3'd1;
        next_rep_nxt       = sat_add(nra, {13'd0, mult[reps]});
      end
      scroll_dir_nxt = dir;
      prev_time_nxt  = in_r.time_ms;
    end

    // mark the final event of the sample
    for (int i = 0; i < EV_SLOTS; i++) begin
      ev_new[i].last = (3'(i) == (n_new - 3'd1));
    end
  end

  // qualifier state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      was_active_r  <= 1'b0;
      trig_held_r   <= 1'b0;
      back_held_r   <= 1'b0;
      back_armed_r  <= 1'b0;
      rel_pending_r <= 1'b0;
      rel_start_r   <= 32'd0;
      scroll_dir_r  <= DIR_NONE;
      next_rep_r    <= 32'd0;
      prev_time_r   <= 32'd0;
    end else if (fire) begin
      was_active_r  <= was_active_nxt;
      trig_held_r   <= trig_held_nxt;
      back_held_r   <= back_held_nxt;
      back_armed_r  <= back_armed_nxt;
      rel_pending_r <= rel_pending_nxt;
      rel_start_r   <= rel_start_nxt;
      scroll_dir_r  <= scroll_dir_nxt;
      next_rep_r    <= next_rep_nxt;
      prev_time_r   <= prev_time_nxt;
    end
  end

  // event queue: load on fire, shift towards the head on pop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
    end else if (fire) begin
      cnt_r <= n_new;
    end else if (pop) begin
      cnt_r <= cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      for (int i = 0; i < EV_SLOTS; i++) slot_r[i] <= ev_new[i];
    end else if (pop) begin
      for (int i = 0; i < EV_SLOTS - 1; i++) slot_r[i] <= slot_r[i + 1];
    end
  end

endmodule
